FILE: hdl/tun_pkg.sv
// Shared types and constants for the triangle unit normal core.
// Used by tun_front, tun_cell and triangle_unit_normal_core; depends on nothing.
package tun_pkg;

  localparam int COORD_W  = 16;
  localparam int OUT_W    = 16;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd2;

  localparam logic [COUNT_W-1:0] MIN_VERTICES_RESET = 8'd3;
  localparam logic [COUNT_W-1:0] MIN_FACE_VERTICES  = 8'd3;

  typedef struct packed {
    logic [COUNT_W-1:0]        vertex_count;
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
  } face_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic [STATUS_W-1:0]     status;
  } normal_t;

  // Control that rides along with each face through the pipeline.
  typedef struct packed {
    logic       valid;
    logic       too_few;
    logic       degen;
    logic [2:0] neg;
  } ctl_t;

endpackage

FILE: hdl/tun_front.sv
// Front pipeline: edges, cross product, exact squares and the squared length,
// then the starting remainders for the root-division cells. Uses tun_pkg.
module tun_front #(
  parameter int CB = 16,
  parameter int FB = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  tun_pkg::face_t              face,
  input  logic [tun_pkg::COUNT_W-1:0] min_vertices,
  output tun_pkg::ctl_t               ctl_out,
  output logic [4*CB+2*FB+9:0]        s_out,
  output logic [2:0][4*CB+2*FB+9:0]   r_out,
  output logic [2:0][4*CB+2*FB+9:0]   p_out
);

  localparam int EW  = CB + 1;
  localparam int PW  = 2 * EW;
  localparam int MW  = 2 * CB + 1;
  localparam int LO  = (MW + 1) / 2;
  localparam int HI  = MW - LO;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int W   = 4 * CB + 2 * FB + 10;

  logic signed [CB-1:0] vc [9];
  logic signed [EW-1:0] ed_next [6];

  tun_pkg::ctl_t        ctl1, ctl2, ctl3, ctl4, ctl5, ctl6;
  tun_pkg::ctl_t        ctl2_neg, ctl6_degen;
  logic signed [EW-1:0] ed1 [6];
  logic signed [PW-1:0] pr2 [6];
  logic [MW-1:0]        mag3 [3];
  logic [2*LO-1:0]      pll4 [3];
  logic [LO+HI-1:0]     plh4 [3];
  logic [2*HI-1:0]      phh4 [3];
  logic [SQW-1:0]       sq5 [3];
  logic [SQW-1:0]       sq6 [3];
  logic [SW-1:0]        s6;
  logic signed [PW-1:0] cr [3];

  // Only the low CB bits of each coordinate take part, sign-extended.
  always_comb begin
    vc[0] = face.v0_x[CB-1:0];
    vc[1] = face.v0_y[CB-1:0];
    vc[2] = face.v0_z[CB-1:0];
    vc[3] = face.v1_x[CB-1:0];
    vc[4] = face.v1_y[CB-1:0];
    vc[5] = face.v1_z[CB-1:0];
    vc[6] = face.v2_x[CB-1:0];
    vc[7] = face.v2_y[CB-1:0];
    vc[8] = face.v2_z[CB-1:0];
    for (int k = 0; k < 3; k++) begin
      ed_next[k]     = {vc[k+3][CB-1], vc[k+3]} - {vc[k][CB-1], vc[k]};
      ed_next[k + 3] = {vc[k+6][CB-1], vc[k+6]} - {vc[k][CB-1], vc[k]};
    end
  end

  always_comb begin
    cr[0] = pr2[0] - pr2[1];
    cr[1] = pr2[2] - pr2[3];
    cr[2] = pr2[4] - pr2[5];
  end

  // Signs of the cross product and the zero-length test join the control here.
  always_comb begin
    ctl2_neg = ctl2;
    for (int k = 0; k < 3; k++) begin
      ctl2_neg.neg[k] = cr[k][PW-1];
    end
    ctl6_degen       = ctl6;
    ctl6_degen.degen = (s6 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl3    <= '0;
      ctl4    <= '0;
      ctl5    <= '0;
      ctl6    <= '0;
      ctl_out <= '0;
    end else begin
      ctl1    <= '{valid:   accept,
                   too_few: (face.vertex_count < min_vertices) ||
                            (face.vertex_count < tun_pkg::MIN_FACE_VERTICES),
                   degen:   1'b0,
                   neg:     3'b000};
      ctl2    <= ctl1;
      ctl3    <= ctl2_neg;
      ctl4    <= ctl3;
      ctl5    <= ctl4;
      ctl6    <= ctl5;
      ctl_out <= ctl6_degen;
    end
  end

  always_ff @(posedge clk) begin
    ed1 <= ed_next;
    // ed1 holds ax, ay, az, bx, by, bz.
    pr2[0] <= ed1[1] * ed1[5];
    pr2[1] <= ed1[2] * ed1[4];
    pr2[2] <= ed1[2] * ed1[3];
    pr2[3] <= ed1[0] * ed1[5];
    pr2[4] <= ed1[0] * ed1[4];
    pr2[5] <= ed1[1] * ed1[3];
    for (int k = 0; k < 3; k++) begin
      mag3[k] <= cr[k][PW-1] ? MW'(-cr[k]) : MW'(cr[k]);
      // Square split into partial products to keep each multiplier narrow.
      pll4[k] <= mag3[k][LO-1:0] * mag3[k][LO-1:0];
      plh4[k] <= mag3[k][LO-1:0] * mag3[k][MW-1:LO];
      phh4[k] <= mag3[k][MW-1:LO] * mag3[k][MW-1:LO];
      sq5[k]  <= SQW'(pll4[k]) + (SQW'(plh4[k]) << (LO + 1)) + (SQW'(phh4[k]) << (2 * LO));
      sq6[k]  <= sq5[k];
      // Remainder starts at A^2 * 4^(FB+1) - S with the trial odd number at -1.
      r_out[k] <= (W'(sq6[k]) << (2 * FB + 2)) - W'(s6);
      p_out[k] <= W'(0) - W'(s6);
    end
    s6    <= SW'(sq5[0]) + SW'(sq5[1]) + SW'(sq5[2]);
    s_out <= W'(s6);
  end

endmodule

FILE: hdl/tun_cell.sv
// One cell of the root-division chain: settles one quotient bit of all three
// components by shift, add and sign test. Uses tun_pkg.
module tun_cell #(
  parameter int CB  = 16,
  parameter int FB  = 14,
  parameter int BIT = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tun_pkg::ctl_t             ctl_in,
  input  logic [4*CB+2*FB+9:0]      s_in,
  input  logic [2:0][4*CB+2*FB+9:0] r_in,
  input  logic [2:0][4*CB+2*FB+9:0] p_in,
  input  logic [2:0][FB:0]          q_in,
  output tun_pkg::ctl_t             ctl_out,
  output logic [4*CB+2*FB+9:0]      s_out,
  output logic [2:0][4*CB+2*FB+9:0] r_out,
  output logic [2:0][4*CB+2*FB+9:0] p_out,
  output logic [2:0][FB:0]          q_out
);

  localparam int W = 4 * CB + 2 * FB + 10;

  logic signed [W-1:0] term [3];
  logic signed [W-1:0] diff [3];
  logic [2:0]          take;

  // With P = (2q-1)S and R = T - (2q-1)^2 S, setting this bit costs
  // 2^(BIT+2) P + 4^(BIT+1) S of the remainder and raises P by 2^(BIT+1) S.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = ($signed(p_in[k]) <<< (BIT + 2)) + $signed(s_in << (2 * BIT + 2));
      diff[k] = $signed(r_in[k]) - term[k];
      take[k] = !q_in[k][FB] && !diff[k][W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    s_out <= s_in;
    for (int k = 0; k < 3; k++) begin
      if (take[k]) begin
        r_out[k] <= diff[k];
        p_out[k] <= p_in[k] + (s_in << (BIT + 1));
        q_out[k] <= q_in[k] | ((FB + 1)'(1) << BIT);
      end else begin
        r_out[k] <= r_in[k];
        p_out[k] <= p_in[k];
        q_out[k] <= q_in[k];
      end
    end
  end

endmodule

FILE: hdl/triangle_unit_normal_core.sv
// Triangle unit normal core: top level with the configuration register,
// the front pipeline, the chain of tun_cell stages and the result register.
// Depends on tun_pkg, tun_front and tun_cell.
//
// A face is taken on a rising edge where start is high and busy is low; busy
// stays low, so a face may be offered on every cycle. Each face gives one
// result beat on result, marked by done for exactly one cycle, after it has
// passed the front pipeline, the cells and the output register. Throughput
// is one face per cycle: seven front stages, one cell per quotient bit and
// the output register all advance together on every clock.
// The configuration channel carries min_vertices; cfg_ready is always high
// and a write takes effect on the edge where cfg_valid is high.
// Faces with fewer vertices than min_vertices (or fewer than three) return a
// zero vector with status too_few; a zero-length cross product returns a zero
// vector with status degenerate.
// Synchronous reset drops all faces in flight and restores min_vertices to 3.
// The receiver cannot hold off results; every done beat must be taken.
module triangle_unit_normal_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  tun_pkg::face_t              face,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tun_pkg::COUNT_W-1:0] cfg_data,
  output logic                        done,
  output tun_pkg::normal_t            result
);

  localparam int W   = 4 * COORD_BITS + 2 * FRAC_BITS + 10;
  localparam int NC  = FRAC_BITS + 1;
  localparam int OW  = (FRAC_BITS + 2 > tun_pkg::OUT_W) ? FRAC_BITS + 2 : tun_pkg::OUT_W;
  localparam int LAT = FRAC_BITS + 9;

  logic [tun_pkg::COUNT_W-1:0] min_vertices;
  logic                        accept;

  tun_pkg::ctl_t              ctl_c [NC+1];
  logic [W-1:0]               s_c   [NC+1];
  logic [2:0][W-1:0]          r_c   [NC+1];
  logic [2:0][W-1:0]          p_c   [NC+1];
  logic [2:0][FRAC_BITS:0]    q_c   [NC+1];

  logic [OW-1:0]              mag [3];
  logic [OW-1:0]              sval [3];
  tun_pkg::normal_t           result_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_vertices <= tun_pkg::MIN_VERTICES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_vertices <= cfg_data;
    end
  end

  tun_front #(
    .CB (COORD_BITS),
    .FB (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .face         (face),
    .min_vertices (min_vertices),
    .ctl_out      (ctl_c[0]),
    .s_out        (s_c[0]),
    .r_out        (r_c[0]),
    .p_out        (p_c[0])
  );

  assign q_c[0] = '0;

  for (genvar j = 0; j < NC; j++) begin : g_cell
    tun_cell #(
      .CB  (COORD_BITS),
      .FB  (FRAC_BITS),
      .BIT (FRAC_BITS - j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_c[j]),
      .s_in    (s_c[j]),
      .r_in    (r_c[j]),
      .p_in    (p_c[j]),
      .q_in    (q_c[j]),
      .ctl_out (ctl_c[j+1]),
      .s_out   (s_c[j+1]),
      .r_out   (r_c[j+1]),
      .p_out   (p_c[j+1]),
      .q_out   (q_c[j+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = OW'(q_c[NC][k]);
      sval[k] = ctl_c[NC].neg[k] ? (OW'(0) - mag[k]) : mag[k];
    end
    result_next.normal_x = sval[0][tun_pkg::OUT_W-1:0];
    result_next.normal_y = sval[1][tun_pkg::OUT_W-1:0];
    result_next.normal_z = sval[2][tun_pkg::OUT_W-1:0];
    result_next.status   = tun_pkg::STATUS_OK;
    if (ctl_c[NC].too_few) begin
      result_next.normal_x = '0;
      result_next.normal_y = '0;
      result_next.normal_z = '0;
      result_next.status   = tun_pkg::STATUS_TOO_FEW;
    end else if (ctl_c[NC].degen) begin
      result_next.normal_x = '0;
      result_next.normal_y = '0;
      result_next.normal_z = '0;
      result_next.status   = tun_pkg::STATUS_DEGENERATE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_c[NC].valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted face produced no result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result beat without a matching accepted face");

  a_zero_on_fault: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != tun_pkg::STATUS_OK) |->
      (result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0))
    else $error("nonzero normal reported with a fault status");

endmodule
